FILE: src/jlr_pkg.sv
`default_nettype none
package jlr_pkg;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_FILL  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_RUN   = 2'd3;

  localparam logic [2:0] REG_ROWS   = 3'd0;
  localparam logic [2:0] REG_COLS   = 3'd1;
  localparam logic [2:0] REG_THRESH = 3'd2;
  localparam logic [2:0] REG_MAXSW  = 3'd3;
  localparam logic [2:0] REG_IFILL  = 3'd4;
  localparam logic [2:0] REG_BFILL  = 3'd5;

  localparam logic [8:0]  ROWS_RST   = 9'd256;
  localparam logic [8:0]  COLS_RST   = 9'd256;
  localparam logic [30:0] THRESH_RST = 31'd6554;
  localparam logic [15:0] MAXSW_RST  = 16'd10;
  localparam logic [31:0] IFILL_RST  = 32'd3276800;
  localparam logic [31:0] BFILL_RST  = 32'd0;

  typedef struct packed {
    logic [8:0]         rows;
    logic [8:0]         cols;
    logic [30:0]        thresh;
    logic [15:0]        max_sweeps;
    logic signed [31:0] ifill;
    logic signed [31:0] bfill;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         func;
    logic               in_mem;
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [31:0] value;
  } cmd_t;

endpackage
`default_nettype wire

FILE: src/jlr_ram.sv
`default_nettype none
module jlr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/jlr_front.sv
`default_nettype none
module jlr_front #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          func,
  input  wire logic [7:0]          row,
  input  wire logic [7:0]          col,
  input  wire logic signed [31:0]  cell_value,
  output logic                     q_valid,
  input  wire logic                q_pop,
  output jlr_pkg::cmd_t            q_head
);

  jlr_pkg::cmd_t entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill_cnt;
  logic       push;
  jlr_pkg::cmd_t cmd_in;

  // classify: flag indexes that fall outside the cell memory
  always_comb begin
    cmd_in.func   = func;
    cmd_in.in_mem = (32'(row) < 32'(MAX_ROWS)) && (32'(col) < 32'(MAX_COLS));
    cmd_in.row    = row;
    cmd_in.col    = col;
    cmd_in.value  = cell_value;
  end

  assign in_stall = (fill_cnt == 3'd4);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill_cnt != 3'd0);
  assign q_head   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      wr_ptr   <= 2'd0;
      rd_ptr   <= 2'd0;
      fill_cnt <= 3'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      fill_cnt <= fill_cnt + 3'(push) - 3'(q_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill_cnt <= 3'd4) else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> fill_cnt != 3'd0) else $error("pop from empty queue");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> fill_cnt == $past(fill_cnt) + 3'd1)
    else $error("queue count lost a push");

endmodule
`default_nettype wire

FILE: src/jlr_back.sv
`default_nettype none
module jlr_back #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire jlr_pkg::cfg_t      cfg,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire jlr_pkg::cmd_t      q_head,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      read_value,
  output logic [15:0]             sweeps_done,
  output logic                    is_stable,
  output logic                    from_run
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int GAW = RW + CW;
  localparam int BAW = CW + 1;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_FILL    = 7'b0000010,
    S_RD      = 7'b0000100,
    S_RD_WAIT = 7'b0001000,
    S_CELL    = 7'b0010000,
    S_WB      = 7'b0100000,
    S_EMIT    = 7'b1000000
  } state_t;

  state_t             state;
  jlr_pkg::cmd_t      cmd;
  logic [RW-1:0]      i;
  logic [CW-1:0]      j;
  logic [RW-1:0]      wb_row;
  logic               wb_ph;
  logic [2:0]         ph;
  logic signed [33:0] sum;
  logic signed [31:0] cval;
  logic signed [31:0] mean;
  logic               sweeping;
  logic [15:0]        sweep_counter;
  logic [15:0]        run_max;
  logic signed [31:0] res_value;
  logic [15:0]        res_count;
  logic               res_st;
  logic               res_run;

  logic [31:0]   rows_v;
  logic [31:0]   cols_v;
  logic [RW-1:0] nr_last;
  logic [CW-1:0] nc_last;

  logic               g_we;
  logic [GAW-1:0]     g_waddr;
  logic [31:0]        g_wdata;
  logic [GAW-1:0]     g_raddr;
  logic [31:0]        g_rdata;
  logic               b_we;
  logic [BAW-1:0]     b_waddr;
  logic [BAW-1:0]     b_raddr;
  logic [31:0]        b_rdata;

  logic signed [32:0] diff;
  logic [32:0]        abs_diff;
  logic               unstable;
  logic               last_i;
  logic               last_j;
  logic               border;
  logic               out_free;

  // grid size clamped to at least 3 and at most the memory
  always_comb begin
    rows_v = 32'(cfg.rows);
    cols_v = 32'(cfg.cols);
    if (rows_v < 32'd3) rows_v = 32'd3;
    if (rows_v > 32'(MAX_ROWS)) rows_v = 32'(MAX_ROWS);
    if (cols_v < 32'd3) cols_v = 32'd3;
    if (cols_v > 32'(MAX_COLS)) cols_v = 32'(MAX_COLS);
    nr_last = RW'(rows_v - 32'd1);
    nc_last = CW'(cols_v - 32'd1);
  end

  assign last_i   = (i == nr_last - RW'(1));
  assign last_j   = (j == nc_last - CW'(1));
  assign border   = (i == '0) || (j == '0) || (i == nr_last) || (j == nc_last);
  assign diff     = 33'(mean) - 33'(cval);
  assign abs_diff = diff[32] ? 33'(-diff) : 33'(diff);
  assign unstable = abs_diff > 33'(cfg.thresh);
  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == S_IDLE) && q_valid;

  always_comb begin
    g_we    = 1'b0;
    g_waddr = {i, j};
    g_wdata = cfg.ifill;
    g_raddr = {RW'(cmd.row), CW'(cmd.col)};
    b_we    = 1'b0;
    b_waddr = {i[0], j};
    b_raddr = {wb_row[0], j};
    case (state)
      S_IDLE: begin
        if (q_pop && q_head.func == jlr_pkg::FUNC_WRITE && q_head.in_mem) begin
          g_we    = 1'b1;
          g_waddr = {RW'(q_head.row), CW'(q_head.col)};
          g_wdata = q_head.value;
        end
      end
      S_FILL: begin
        g_we    = 1'b1;
        g_wdata = border ? cfg.bfill : cfg.ifill;
      end
      S_CELL: begin
        case (ph)
          3'd0:    g_raddr = {i - RW'(1), j};
          3'd1:    g_raddr = {i + RW'(1), j};
          3'd2:    g_raddr = {i, j - CW'(1)};
          3'd3:    g_raddr = {i, j + CW'(1)};
          default: g_raddr = {i, j};
        endcase
        b_we = sweeping && (ph == 3'd7);
      end
      S_WB: begin
        g_we    = wb_ph;
        g_waddr = {wb_row, j};
        g_wdata = b_rdata;
      end
      default: ;
    endcase
  end

  jlr_ram #(.WIDTH(32), .DEPTH(2 ** GAW)) u_grid (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  jlr_ram #(.WIDTH(32), .DEPTH(2 ** BAW)) u_row_window (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (mean),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      sweep_counter <= 16'd0;
      sweeping      <= 1'b0;
      ph            <= 3'd0;
      wb_ph         <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            cmd <= q_head;
            case (q_head.func)
              jlr_pkg::FUNC_FILL: begin
                i     <= '0;
                j     <= '0;
                state <= S_FILL;
              end
              jlr_pkg::FUNC_READ: state <= S_RD;
              jlr_pkg::FUNC_RUN: begin
                sweep_counter <= 16'd0;
                run_max       <= cfg.max_sweeps;
                sweeping      <= 1'b0;
                i             <= RW'(1);
                j             <= CW'(1);
                ph            <= 3'd0;
                state         <= S_CELL;
              end
              default: ;
            endcase
          end
        end
        S_FILL: begin
          if (j == nc_last) begin
            j <= '0;
            if (i == nr_last) begin
              state <= S_IDLE;
            end else begin
              i <= i + RW'(1);
            end
          end else begin
            j <= j + CW'(1);
          end
        end
        S_RD: state <= S_RD_WAIT;
        S_RD_WAIT: begin
          res_value <= cmd.in_mem ? g_rdata : 32'sd0;
          res_count <= 16'd0;
          res_st    <= 1'b0;
          res_run   <= 1'b0;
          state     <= S_EMIT;
        end
        S_CELL: begin
          ph <= ph + 3'd1;
          case (ph)
            3'd1:    sum  <= 34'(signed'(g_rdata));
            3'd2,
            3'd3,
            3'd4:    sum  <= sum + 34'(signed'(g_rdata));
            3'd5:    cval <= g_rdata;
            3'd6:    mean <= sum[33:2];
            3'd7: begin
              if (!sweeping) begin
                if (unstable || (last_i && last_j)) begin
                  if (!unstable || sweep_counter >= run_max) begin
                    res_value <= 32'sd0;
                    res_count <= sweep_counter;
                    res_st    <= !unstable;
                    res_run   <= 1'b1;
                    state     <= S_EMIT;
                  end else begin
                    sweeping <= 1'b1;
                    i        <= RW'(1);
                    j        <= CW'(1);
                  end
                end else if (last_j) begin
                  j <= CW'(1);
                  i <= i + RW'(1);
                end else begin
                  j <= j + CW'(1);
                end
              end else if (last_j) begin
                j     <= CW'(1);
                wb_ph <= 1'b0;
                if (i > RW'(1)) begin
                  wb_row <= i - RW'(1);
                  state  <= S_WB;
                end else if (last_i) begin
                  wb_row <= i;
                  state  <= S_WB;
                end else begin
                  i <= i + RW'(1);
                end
              end else begin
                j <= j + CW'(1);
              end
            end
            default: ;
          endcase
        end
        S_WB: begin
          wb_ph <= !wb_ph;
          if (wb_ph) begin
            if (last_j) begin
              j <= CW'(1);
              if (wb_row == nr_last - RW'(1)) begin
                sweep_counter <= sweep_counter + 16'd1;
                sweeping      <= 1'b0;
                i             <= RW'(1);
                ph            <= 3'd0;
                state         <= S_CELL;
              end else if (last_i) begin
                wb_row <= i;
              end else begin
                i     <= i + RW'(1);
                ph    <= 3'd0;
                state <= S_CELL;
              end
            end else begin
              j <= j + CW'(1);
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            read_value  <= res_value;
            sweeps_done <= res_count;
            is_stable   <= res_st;
            from_run    <= res_run;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    state == S_CELL |-> sweep_counter <= run_max) else $error("sweep count past limit");
  a_wb_in_sweep: assert property (@(posedge clk) disable iff (rst)
    state == S_WB |-> sweeping) else $error("write-back outside a sweep");
  a_wb_row: assert property (@(posedge clk) disable iff (rst)
    state == S_WB |-> wb_row <= i) else $error("write-back ahead of compute");
  a_emit_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |=> state == S_EMIT || state == S_IDLE) else $error("bad exit from emit");

endmodule
`default_nettype wire

FILE: src/jacobi_laplace_relaxation.sv
`default_nettype none
// channel | direction | handshake            | payload
// in      | in        | in_valid / in_stall   | func, row, col, cell_value
// out     | out       | out_valid / out_stall | read_value, sweeps_done, is_stable, from_run
// cfg     | in        | psel/penable/pready   | paddr, pwdata, prdata
//
// fill: rows*cols cells, one write a cycle
// run: a stability pass checks the interior cells in turn (it stops at the first unstable
// cell), and each sweep computes every interior cell and writes it back from a row window,
// then the result is emitted; cells are read one at a time through the single grid read port
// a 4-entry queue lets the input side keep taking transactions while the executor is busy
// reset (synchronous) clears control state only; the grid needs no clearing pass
// a waiting result sits in the output register while the next transaction is executed
module jacobi_laplace_relaxation #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // item input
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         func,
  input  wire logic [7:0]         row,
  input  wire logic [7:0]         col,
  input  wire logic signed [31:0] cell_value,
  // result output
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      read_value,
  output logic [15:0]             sweeps_done,
  output logic                    is_stable,
  output logic                    from_run,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  jlr_pkg::cfg_t cfg;
  jlr_pkg::cmd_t q_head;
  logic          q_valid;
  logic          q_pop;
  logic          cfg_wr;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // register file; the user must write it only while the block is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows       <= jlr_pkg::ROWS_RST;
      cfg.cols       <= jlr_pkg::COLS_RST;
      cfg.thresh     <= jlr_pkg::THRESH_RST;
      cfg.max_sweeps <= jlr_pkg::MAXSW_RST;
      cfg.ifill      <= jlr_pkg::IFILL_RST;
      cfg.bfill      <= jlr_pkg::BFILL_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        jlr_pkg::REG_ROWS:   cfg.rows       <= pwdata[8:0];
        jlr_pkg::REG_COLS:   cfg.cols       <= pwdata[8:0];
        jlr_pkg::REG_THRESH: cfg.thresh     <= pwdata[30:0];
        jlr_pkg::REG_MAXSW:  cfg.max_sweeps <= pwdata[15:0];
        jlr_pkg::REG_IFILL:  cfg.ifill      <= pwdata;
        jlr_pkg::REG_BFILL:  cfg.bfill      <= pwdata;
        default: ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    case (reg_idx)
      jlr_pkg::REG_ROWS:   prdata = 32'(cfg.rows);
      jlr_pkg::REG_COLS:   prdata = 32'(cfg.cols);
      jlr_pkg::REG_THRESH: prdata = 32'(cfg.thresh);
      jlr_pkg::REG_MAXSW:  prdata = 32'(cfg.max_sweeps);
      jlr_pkg::REG_IFILL:  prdata = cfg.ifill;
      jlr_pkg::REG_BFILL:  prdata = cfg.bfill;
      default:             prdata = 32'd0;
    endcase
  end

  // front: takes and classifies transactions into the queue
  jlr_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .row        (row),
    .col        (col),
    .cell_value (cell_value),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_head     (q_head)
  );

  // back: grid memory, write, fill, read and relaxation sequencer
  jlr_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_head      (q_head),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_value  (read_value),
    .sweeps_done (sweeps_done),
    .is_stable   (is_stable),
    .from_run    (from_run)
  );

endmodule
`default_nettype wire

FILE: dv/jacobi_laplace_relaxation_chk.sv
`default_nettype none
module jacobi_laplace_relaxation_chk (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [1:0]         func,
  input  wire logic [7:0]         row,
  input  wire logic [7:0]         col,
  input  wire logic signed [31:0] cell_value,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [31:0] read_value,
  input  wire logic [15:0]        sweeps_done,
  input  wire logic               is_stable,
  input  wire logic               from_run,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic               pready,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output int                      fail_count,
  output int                      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] rv;
    logic [15:0]        sw;
    logic               st;
    logic               fr;
  } grid_result_t;

  jlr_pkg::cfg_t       cfg;
  logic signed [31:0]  grid [256][256];
  logic signed [31:0]  fresh [256][256];
  grid_result_t        result_fifo [$];

  function automatic int clamp_dim(logic [8:0] v);
    if (v < 3) return 3;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  // floor of the exact sum over four
  function automatic logic signed [31:0] nb_mean(int i, int j);
    longint s;
    s = longint'(grid[i-1][j]) + longint'(grid[i+1][j]) + longint'(grid[i][j-1])
      + longint'(grid[i][j+1]);
    return 32'(s >>> 2);
  endfunction

  function automatic bit settled(int nr, int nc);
    longint d;
    for (int i = 1; i + 1 < nr; i++)
      for (int j = 1; j + 1 < nc; j++) begin
        d = longint'(nb_mean(i, j)) - longint'(grid[i][j]);
        if (d < 0) d = -d;
        if (d > longint'(cfg.thresh)) return 0;
      end
    return 1;
  endfunction

  task automatic relax_and_predict(output grid_result_t r);
    int nr, nc;
    bit st;
    logic [15:0] n;
    nr = clamp_dim(cfg.rows);
    nc = clamp_dim(cfg.cols);
    n = 0;
    st = settled(nr, nc);
    while (!st && n < cfg.max_sweeps) begin
      for (int i = 1; i + 1 < nr; i++)
        for (int j = 1; j + 1 < nc; j++) fresh[i][j] = nb_mean(i, j);
      for (int i = 1; i + 1 < nr; i++)
        for (int j = 1; j + 1 < nc; j++) grid[i][j] = fresh[i][j];
      n++;
      st = settled(nr, nc);
    end
    r = '{rv: 0, sw: n, st: st, fr: 1'b1};
  endtask

  always @(posedge clk) begin
    grid_result_t r, e;
    int nr, nc;
    if (rst) begin
      cfg <= '{jlr_pkg::ROWS_RST, jlr_pkg::COLS_RST, jlr_pkg::THRESH_RST,
               jlr_pkg::MAXSW_RST, jlr_pkg::IFILL_RST, jlr_pkg::BFILL_RST};
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          jlr_pkg::REG_ROWS:   cfg.rows       <= pwdata[8:0];
          jlr_pkg::REG_COLS:   cfg.cols       <= pwdata[8:0];
          jlr_pkg::REG_THRESH: cfg.thresh     <= pwdata[30:0];
          jlr_pkg::REG_MAXSW:  cfg.max_sweeps <= pwdata[15:0];
          jlr_pkg::REG_IFILL:  cfg.ifill      <= pwdata;
          jlr_pkg::REG_BFILL:  cfg.bfill      <= pwdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (func)
          jlr_pkg::FUNC_WRITE: grid[row][col] = cell_value;
          jlr_pkg::FUNC_FILL: begin
            nr = clamp_dim(cfg.rows);
            nc = clamp_dim(cfg.cols);
            for (int i = 0; i < nr; i++)
              for (int j = 0; j < nc; j++)
                grid[i][j] = (i == 0 || j == 0 || i == nr - 1 || j == nc - 1) ?
                             cfg.bfill : cfg.ifill;
          end
          jlr_pkg::FUNC_READ: begin
            r = '{rv: grid[row][col], sw: 0, st: 0, fr: 0};
            result_fifo.push_back(r);
          end
          default: begin
            relax_and_predict(r);
            result_fifo.push_back(r);
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        if (result_fifo.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transaction at %0t", $realtime);
        end else begin
          e = result_fifo.pop_front();
          if (read_value !== e.rv || sweeps_done !== e.sw || is_stable !== e.st ||
              from_run !== e.fr) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch at %0t: exp rv=%0d sw=%0d st=%0b fr=%0b ",
                        "got rv=%0d sw=%0d st=%0b fr=%0b"},
                       $realtime, e.rv, e.sw, e.st, e.fr, read_value, sweeps_done,
                       is_stable, from_run);
          end
        end
      end
    end
    outstanding = result_fifo.size();
  end

endmodule
`default_nettype wire

FILE: dv/jacobi_laplace_relaxation_tb.sv
`default_nettype none
module jacobi_laplace_relaxation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         func = jlr_pkg::FUNC_WRITE;
  logic [7:0]         row = '0;
  logic [7:0]         col = '0;
  logic signed [31:0] cell_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] read_value;
  logic [15:0]        sweeps_done;
  logic               is_stable;
  logic               from_run;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 fail_count;
  int                 outstanding;

  // stimulus-side view of the grid size, so fills mark the right cells
  int                 grid_rows = 256;
  int                 grid_cols = 256;
  bit                 gaps_on = 1'b1;
  bit                 hold_req = 1'b0;
  bit                 touched [256][256];
  logic [15:0]        touched_list [$];

  always #5 clk = ~clk;

  jacobi_laplace_relaxation u_top (
    .clk, .rst, .in_valid, .in_stall, .func, .row, .col, .cell_value,
    .out_valid, .out_stall, .read_value, .sweeps_done, .is_stable, .from_run,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  jacobi_laplace_relaxation_chk u_chk (
    .clk, .rst, .in_valid, .in_stall, .func, .row, .col, .cell_value,
    .out_valid, .out_stall, .read_value, .sweeps_done, .is_stable, .from_run,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .fail_count, .outstanding
  );

  function automatic int clamp_dim(logic [8:0] v);
    if (v < 3) return 3;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  function automatic void mark_cell(int r, int c);
    if (!touched[r][c]) begin
      touched[r][c] = 1'b1;
      touched_list.push_back({r[7:0], c[7:0]});
    end
  endfunction

  // one transaction on the item channel; valid stays high across back-to-back items when no gap is drawn
  task automatic send_item(logic [1:0] f, logic [7:0] r, logic [7:0] c, logic [31:0] v);
    int gap;
    gap = gaps_on ? $urandom_range(0, 16) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    func <= f;
    row <= r;
    col <= c;
    cell_value <= v;
    do @(posedge clk); while (in_stall);
    if (f == jlr_pkg::FUNC_WRITE) mark_cell(r, c);
    if (f == jlr_pkg::FUNC_FILL)
      for (int i = 0; i < grid_rows; i++)
        for (int j = 0; j < grid_cols; j++) mark_cell(i, j);
  endtask

  task automatic read_touched();
    logic [15:0] a;
    a = touched_list[$urandom_range(0, touched_list.size() - 1)];
    send_item(jlr_pkg::FUNC_READ, a[15:8], a[7:0], $urandom);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] d);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // every phase ends with a read, so once nothing is outstanding the executor is idle
  task automatic set_grid(logic [8:0] r, logic [8:0] c, logic [30:0] t, logic [15:0] m,
                          logic [31:0] ifl, logic [31:0] bfl);
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    apb_write(jlr_pkg::REG_ROWS, {23'd0, r});
    apb_write(jlr_pkg::REG_COLS, {23'd0, c});
    apb_write(jlr_pkg::REG_THRESH, {1'b0, t});
    apb_write(jlr_pkg::REG_MAXSW, {16'd0, m});
    apb_write(jlr_pkg::REG_IFILL, ifl);
    apb_write(jlr_pkg::REG_BFILL, bfl);
    grid_rows = clamp_dim(r);
    grid_cols = clamp_dim(c);
  endtask

  // result side: a random hold-off before each transaction when gaps are on, plus one long one on request
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        repeat (3000) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        hold_req = 1'b0;
      end
      n = gaps_on ? $urandom_range(0, 16) : 0;
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #50ms;
    $display("jacobi_laplace_relaxation regression: fail");
    $finish;
  end

  initial begin
    logic [8:0] r9, c9;
    logic [30:0] th;
    int pick;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extreme fills on the smallest grid, zero sweep limit
    set_grid(9'd3, 9'd3, 31'd0, 16'd0, 32'h7fffffff, 32'h80000000);
    send_item(jlr_pkg::FUNC_FILL, 8'd0, 8'd0, 32'd0);
    send_item(jlr_pkg::FUNC_READ, 8'd0, 8'd0, 32'd0);
    send_item(jlr_pkg::FUNC_READ, 8'd1, 8'd1, 32'd0);
    send_item(jlr_pkg::FUNC_RUN, 8'd0, 8'd0, 32'd0);
    // cells outside the grid but inside memory
    send_item(jlr_pkg::FUNC_WRITE, 8'd255, 8'd255, 32'h80000000);
    send_item(jlr_pkg::FUNC_WRITE, 8'd0, 8'd255, 32'h7fffffff);
    send_item(jlr_pkg::FUNC_WRITE, 8'd255, 8'd0, 32'hffffffff);
    send_item(jlr_pkg::FUNC_READ, 8'd255, 8'd255, 32'd0);
    send_item(jlr_pkg::FUNC_READ, 8'd0, 8'd255, 32'd0);
    send_item(jlr_pkg::FUNC_READ, 8'd255, 8'd0, 32'd0);
    // largest sweep limit, on a grid that is already settled and on one that is not
    set_grid(9'd3, 9'd3, 31'h7fffffff, 16'hffff, 32'h80000000, 32'h7fffffff);
    send_item(jlr_pkg::FUNC_FILL, 8'd0, 8'd0, 32'd0);
    send_item(jlr_pkg::FUNC_WRITE, 8'd1, 8'd1, 32'h12345678);
    send_item(jlr_pkg::FUNC_RUN, 8'd0, 8'd0, 32'd0);
    send_item(jlr_pkg::FUNC_READ, 8'd1, 8'd1, 32'd0);
    set_grid(9'd3, 9'd3, 31'd0, 16'hffff, 32'd0, 32'h00010000);
    send_item(jlr_pkg::FUNC_WRITE, 8'd1, 8'd1, 32'hdeadbeef);
    send_item(jlr_pkg::FUNC_RUN, 8'd0, 8'd0, 32'd0);
    send_item(jlr_pkg::FUNC_READ, 8'd1, 8'd1, 32'd0);
    // oversized rows and undersized cols saturate to 256 by 3
    set_grid(9'd511, 9'd2, 31'd6554, 16'd3, jlr_pkg::IFILL_RST, jlr_pkg::BFILL_RST);
    send_item(jlr_pkg::FUNC_FILL, 8'd0, 8'd0, 32'd0);
    send_item(jlr_pkg::FUNC_WRITE, 8'd128, 8'd1, 32'h00640000);
    send_item(jlr_pkg::FUNC_RUN, 8'd0, 8'd0, 32'd0);
    send_item(jlr_pkg::FUNC_READ, 8'd255, 8'd2, 32'd0);
    send_item(jlr_pkg::FUNC_READ, 8'd127, 8'd1, 32'd0);

    // random phases on small grids
    for (int ph = 0; ph < 18; ph++) begin
      r9 = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 2)) : 9'($urandom_range(3, 8));
      c9 = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 2)) : 9'($urandom_range(3, 8));
      case ($urandom_range(0, 3))
        0: th = 31'd0;
        1: th = 31'($urandom_range(0, 200000));
        2: th = 31'h7fffffff;
        default: th = 31'($urandom);
      endcase
      set_grid(r9, c9, th, 16'($urandom_range(0, 12)), $urandom, $urandom);
      gaps_on = (ph % 4) != 1;
      send_item(jlr_pkg::FUNC_FILL, 8'd0, 8'd0, $urandom);
      if (ph == 5) begin
        // long receiver hold-off while reads keep arriving
        hold_req = 1'b1;
        repeat (30) read_touched();
      end
      repeat (100) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          if ($urandom_range(0, 3) == 0)
            send_item(jlr_pkg::FUNC_WRITE, 8'($urandom), 8'($urandom), $urandom);
          else
            send_item(jlr_pkg::FUNC_WRITE, 8'($urandom_range(0, grid_rows - 1)),
                      8'($urandom_range(0, grid_cols - 1)), $urandom);
        end else if (pick < 90) begin
          read_touched();
        end else if (pick < 94) begin
          send_item(jlr_pkg::FUNC_FILL, 8'($urandom), 8'($urandom), $urandom);
        end else begin
          send_item(jlr_pkg::FUNC_RUN, 8'($urandom), 8'($urandom), $urandom);
        end
      end
      read_touched();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("jacobi_laplace_relaxation regression: pass");
    end else begin
      $display("jacobi_laplace_relaxation regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
